>>> hdl/tip_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tip_pkg
// Shared types, character codes and helpers for the text-to-integer parser.
// ----------------------------------------------------------------------------
package tip_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
        logic [5:0] radix_req;
    } t_in_beat;

    typedef struct packed {
        logic signed [63:0] value;
        logic [12:0]        consumed;
        logic               stop_reason;
    } t_out_beat;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WS,
        PH_START,
        PH_ZERO,
        PH_DIGITS
    } t_phase;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;

    localparam logic [5:0] RADIX_AUTO = 6'd0;
    localparam logic [5:0] RADIX_OCT  = 6'd8;
    localparam logic [5:0] RADIX_DEC  = 6'd10;
    localparam logic [5:0] RADIX_HEX  = 6'd16;

    localparam logic [6:0] NOT_DIGIT  = 7'h7F;

    localparam logic STOP_TERM    = 1'b0;
    localparam logic STOP_INVALID = 1'b1;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
    endfunction

    // Digit value 0..35, or NOT_DIGIT (above any 6-bit radix)
    function automatic logic [6:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'(NOT_DIGIT);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = c - CH_LO_A + 8'd10;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = c - CH_UP_A + 8'd10;
        end
        return d[6:0];
    endfunction

endpackage
`default_nettype wire

>>> hdl/tip_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tip_core
// Parse state and per-character step: whitespace, sign, prefix, digits.
// ----------------------------------------------------------------------------
module tip_core #(
    parameter int MAX_CHARS = 4096
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_step,
    input  tip_pkg::t_in_beat   i_beat,
    output logic                o_res_valid,
    output tip_pkg::t_out_beat  o_res
);
    import tip_pkg::*;

    localparam int CW = $clog2(MAX_CHARS + 1);

    t_phase         r_phase, n_phase;
    logic [63:0]    r_acc, n_acc;
    logic           r_neg, n_neg;
    logic [5:0]     r_radix, n_radix;
    logic [CW-1:0]  r_cnt, n_cnt;

    // state as seen by this character (a first beat restarts the string)
    t_phase         e_phase;
    logic [63:0]    e_acc;
    logic           e_neg;
    logic [5:0]     e_radix;
    logic [CW-1:0]  e_cnt;
    logic [CW-1:0]  cnt_inc;

    logic [7:0]     c;
    logic [6:0]     dig;
    logic           dg_go;
    logic [5:0]     dg_radix;
    logic           stop_term, stop_bad;

    assign c       = i_beat.ch;
    assign dig     = digit_of(c);
    assign e_phase = i_beat.first ? PH_WS : r_phase;
    assign e_acc   = i_beat.first ? '0 : r_acc;
    assign e_neg   = i_beat.first ? 1'b0 : r_neg;
    assign e_radix = i_beat.first ? i_beat.radix_req : r_radix;
    assign e_cnt   = i_beat.first ? '0 : r_cnt;
    assign cnt_inc = (e_cnt < CW'(MAX_CHARS)) ? CW'(e_cnt + 1'b1) : e_cnt;

    assign stop_term = (c == CH_NUL);

    // next state
    always_comb begin
        n_phase  = e_phase;
        n_acc    = e_acc;
        n_neg    = e_neg;
        n_radix  = e_radix;
        n_cnt    = e_cnt;
        dg_go    = 1'b0;
        dg_radix = e_radix;
        unique case (e_phase)
            PH_IDLE: begin
            end
            PH_WS, PH_START: begin
                if (e_phase == PH_WS && is_ws(c)) begin
                    n_cnt = cnt_inc;
                end else if (e_phase == PH_WS && (c == CH_PLUS || c == CH_MINUS)) begin
                    n_neg   = (c == CH_MINUS);
                    n_cnt   = cnt_inc;
                    n_phase = PH_START;
                end else if ((e_radix == RADIX_AUTO || e_radix == RADIX_HEX) &&
                             c == CH_ZERO) begin
                    n_cnt   = cnt_inc;
                    n_phase = PH_ZERO;
                end else begin
                    dg_go    = 1'b1;
                    dg_radix = (e_radix == RADIX_AUTO) ? RADIX_DEC : e_radix;
                end
            end
            PH_ZERO: begin
                if (c == CH_LO_X || c == CH_UP_X) begin
                    n_radix = RADIX_HEX;
                    n_cnt   = cnt_inc;
                    n_phase = PH_DIGITS;
                end else begin
                    dg_go    = 1'b1;
                    dg_radix = (e_radix == RADIX_AUTO) ? RADIX_OCT : e_radix;
                end
            end
            PH_DIGITS: begin
                dg_go = 1'b1;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        stop_bad = (dig >= {1'b0, dg_radix});
        if (dg_go) begin
            n_radix = dg_radix;
            if (stop_term || stop_bad) begin
                n_phase = PH_IDLE;
            end else begin
                n_acc   = (e_acc * 64'(dg_radix)) + 64'(dig[5:0]);
                n_cnt   = cnt_inc;
                n_phase = PH_DIGITS;
            end
        end
    end

    // outputs
    always_comb begin
        o_res_valid       = i_step && dg_go && (stop_term || stop_bad);
        o_res.value       = e_neg ? -e_acc : e_acc;
        o_res.consumed    = 13'(e_cnt);
        o_res.stop_reason = stop_term ? STOP_TERM : STOP_INVALID;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_radix <= '0;
            r_cnt   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_radix <= n_radix;
            r_cnt   <= n_cnt;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_CHARS))
        else $error("char count beyond limit");
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> r_phase == PH_IDLE)
        else $error("parse not closed after result");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE && !i_beat.first) |-> !o_res_valid)
        else $error("result while idle");
`endif

endmodule
`default_nettype wire

>>> hdl/text_to_integer_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_to_integer_parser
// Streaming strtoll-style converter: one character per beat, at most one
// result per string (value, characters consumed, stop reason).
// ----------------------------------------------------------------------------
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+-----------------------------------
//  in      | i_in_valid  | o_in_stall  | i_in_beat  (ch, first, radix_req)
//  out     | o_out_valid | i_out_stall | o_out_beat (value, consumed, stop)
//
//  One character per cycle while the output is not stalled. A beat lands
//  in the input register, is stepped through the 64x6 multiply-add of
//  tip_core once the output register can advance, and its result (if any)
//  is loaded into the output register at the end of that step's cycle.
//  Synchronous active-low reset returns the parser to idle; characters are
//  ignored until a beat marked first arrives.
//  A stalled output holds both stages; the input register still takes one
//  more beat while the result waits.
// ----------------------------------------------------------------------------
module text_to_integer_parser #(
    parameter int MAX_CHARS = 4096
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  tip_pkg::t_in_beat   i_in_beat,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output tip_pkg::t_out_beat  o_out_beat
);
    import tip_pkg::*;

    logic       r_in_vld;
    t_in_beat   r_in;
    logic       r_out_vld;
    t_out_beat  r_out;

    logic       adv;        // step stage may move this cycle
    logic       step;       // a held beat is stepped now
    logic       res_vld;
    t_out_beat  res;

    // Advance whenever the output register is empty or being drained.
    assign adv        = !r_out_vld || !i_out_stall;
    assign step       = r_in_vld && adv;
    assign o_in_stall = r_in_vld && !adv;

    tip_core #(
        .MAX_CHARS (MAX_CHARS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_beat      (r_in),
        .o_res_valid (res_vld),
        .o_res       (res)
    );

    // Input register: take a new beat unless the held one is blocked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_beat;
        end
    end

    // Output register: load a result, or drop the drained one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res_vld) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out;

`ifndef NO_ASSERTIONS
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_vld && i_out_stall && r_in_vld))
        else $error("input stalled without output backpressure");
    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> (r_in_vld && $stable(r_in)))
        else $error("held beat lost under stall");
    a_res_only_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_vld |-> step)
        else $error("result without a stepped beat");
`endif

endmodule
`default_nettype wire

>>> tb/text_to_integer_parser_tb.sv
// ----------------------------------------------------------------------------
// text_to_integer_parser_tb
// Streams strings one character per beat into the parser and checks each
// result (value, characters consumed, stop reason) against a cycle-free
// predictor. Directed strings hit the corner cases, then random strings
// run under three idling profiles on the input and output channels.
// ----------------------------------------------------------------------------
import tip_pkg::*;

// Predicts the parser from the accepted input beats and checks its results.
class parse_scoreboard;
    int unsigned count_cap;
    t_phase      phase;
    logic [63:0] acc;
    logic        neg;
    logic [5:0]  base;
    logic [12:0] taken;
    t_out_beat   pending_results[$];
    int unsigned errors;
    int unsigned results_seen;

    function new(int unsigned cap);
        count_cap    = cap;
        phase        = PH_IDLE;
        acc          = '0;
        neg          = 1'b0;
        base         = '0;
        taken        = '0;
        errors       = 0;
        results_seen = 0;
    endfunction

    function int unsigned outstanding();
        return pending_results.size();
    endfunction

    function bit is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF ||
               c == CH_CR || c == CH_VT || c == CH_FF;
    endfunction

    // 0..35 for digit characters, 8'hFF for anything else
    function logic [7:0] digit_value(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
        if (c >= CH_LO_A && c <= CH_LO_Z) return c - CH_LO_A + 8'd10;
        if (c >= CH_UP_A && c <= CH_UP_Z) return c - CH_UP_A + 8'd10;
        return 8'hFF;
    endfunction

    function void bump();
        if (taken < count_cap) taken++;
    endfunction

    function void close(logic reason);
        t_out_beat r;
        r.value       = neg ? 64'd0 - acc : acc;
        r.consumed    = taken;
        r.stop_reason = reason;
        pending_results.push_back(r);
        phase = PH_IDLE;
    endfunction

    function void note_char(t_in_beat b);
        logic [7:0] c;
        logic [7:0] d;
        c = b.ch;
        if (b.first) begin
            phase = PH_WS;
            acc   = '0;
            neg   = 1'b0;
            base  = b.radix_req;
            taken = '0;
        end
        if (phase == PH_IDLE) return;
        if (phase == PH_WS) begin
            if (is_blank(c)) begin
                bump();
                return;
            end
            if (c == CH_MINUS || c == CH_PLUS) begin
                neg = (c == CH_MINUS);
                bump();
                phase = PH_START;
                return;
            end
            phase = PH_START;
        end
        if (phase == PH_START) begin
            if ((base == RADIX_AUTO || base == RADIX_HEX) && c == CH_ZERO) begin
                bump();
                phase = PH_ZERO;
                return;
            end
            if (base == RADIX_AUTO) base = RADIX_DEC;
            phase = PH_DIGITS;
        end else if (phase == PH_ZERO) begin
            if (c == CH_LO_X || c == CH_UP_X) begin
                base = RADIX_HEX;
                bump();
                phase = PH_DIGITS;
                return;
            end
            if (base == RADIX_AUTO) base = RADIX_OCT;
            phase = PH_DIGITS;
        end
        if (c == CH_NUL) begin
            close(STOP_TERM);
            return;
        end
        d = digit_value(c);
        if (d >= {2'b00, base}) begin
            close(STOP_INVALID);
            return;
        end
        acc = acc * 64'(base) + 64'(d);
        bump();
    endfunction

    function void flag(string msg);
        errors++;
        if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_result(t_out_beat got);
        t_out_beat want;
        results_seen++;
        if (pending_results.size() == 0) begin
            flag($sformatf("unexpected result value=%0d consumed=%0d stop=%0b",
                           got.value, got.consumed, got.stop_reason));
            return;
        end
        want = pending_results.pop_front();
        if (got.value !== want.value || got.consumed !== want.consumed ||
            got.stop_reason !== want.stop_reason) begin
            flag($sformatf({"expected value=%0d consumed=%0d stop=%0b, ",
                            "got value=%0d consumed=%0d stop=%0b"},
                           want.value, want.consumed, want.stop_reason,
                           got.value, got.consumed, got.stop_reason));
        end
    endfunction

    function void close_out();
        while (pending_results.size() != 0) begin
            void'(pending_results.pop_front());
            flag("expected result never arrived");
        end
    endfunction
endclass

module text_to_integer_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CHARS = 4096;
    localparam int RANDOM_ITEMS = 1000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_beat   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_beat out_beat;

    // Idling odds in percent, changed per phase of the run
    int unsigned send_idle_pct = 29;
    int unsigned out_stall_pct = 58;

    // Next beat opens a new string when lead is set
    bit          lead       = 1'b0;
    logic [5:0]  lead_radix = '0;
    int unsigned chars_sent = 0;
    int unsigned strings_opened = 0;

    parse_scoreboard sb;

    text_to_integer_parser #(
        .MAX_CHARS(MAX_CHARS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_beat  (in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_beat (out_beat)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the handshake hangs
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: stall at random with the current odds
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // Check every result beat taken by the receiver
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_result(out_beat);
        end
    end

    // Present one beat, hold it through stalls, and note it once accepted.
    // Valid is only lowered in steps that are followed by a clock edge.
    task automatic push_char(input logic [7:0] c, input bit is_first,
                             input logic [5:0] rdx);
        t_in_beat b;
        b.ch        = c;
        b.first     = is_first;
        b.radix_req = rdx;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_char(b);
    endtask

    // Send one character of the current string; the radix field is noise
    // on beats that do not open a string.
    task automatic put(input logic [7:0] c);
        if (lead) strings_opened++;
        push_char(c, lead, lead ? lead_radix : 6'($urandom_range(63)));
        chars_sent++;
        lead = 1'b0;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endtask

    task automatic open_text(input logic [5:0] rdx, input string s);
        lead       = 1'b1;
        lead_radix = rdx;
        put_text(s);
    endtask

    // Hold the input off until every expected result has been taken
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.outstanding() != 0);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(5))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_CR;
            4:       return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    function automatic logic [7:0] digit_char(input int v);
        if (v < 10) return CH_ZERO + 8'(v);
        return ($urandom_range(1) ? CH_LO_A : CH_UP_A) + 8'(v - 10);
    endfunction

    // One random string: mostly well formed (blanks, sign, prefix, digits in
    // range, terminator) with the odd bad character; some pure noise.
    task automatic random_text();
        logic [5:0] rdx;
        int         eff;
        int         n;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 35)      rdx = RADIX_AUTO;
        else if (pick < 55) rdx = RADIX_DEC;
        else if (pick < 70) rdx = RADIX_HEX;
        else if (pick < 80) rdx = RADIX_OCT;
        else                rdx = 6'($urandom_range(63));
        lead       = 1'b1;
        lead_radix = rdx;

        if ($urandom_range(9) == 0) begin
            // noise, with an occasional restart in the middle
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
                if (i != 0 && $urandom_range(15) == 0) begin
                    lead       = 1'b1;
                    lead_radix = 6'($urandom_range(63));
                end
                put(8'($urandom_range(255)));
            end
            return;
        end

        eff = (rdx == RADIX_AUTO) ? 10 : int'(rdx);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) put(pick_blank());
        case ($urandom_range(2))
            0:       put(CH_PLUS);
            1:       put(CH_MINUS);
            default: ;
        endcase
        if ((rdx == RADIX_AUTO || rdx == RADIX_HEX) && $urandom_range(2) == 0) begin
            put(CH_ZERO);
            put($urandom_range(1) ? CH_LO_X : CH_UP_X);
            eff = 16;
        end else if (rdx == RADIX_AUTO && $urandom_range(3) == 0) begin
            put(CH_ZERO);
            eff = 8;
        end
        if (eff > 36) eff = 36;

        n = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 20);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(24) == 0)
                put(8'($urandom_range(255)));
            else if (eff <= 1)
                put(digit_char($urandom_range(35)));
            else
                put(digit_char($urandom_range(eff - 1)));
        end

        pick = $urandom_range(9);
        if (pick < 6)      put(CH_NUL);
        else if (pick < 9) put(8'($urandom_range(255)));
        else               return;  // left open, the next string abandons it

        // trailing characters after the result are dropped by the parser
        if ($urandom_range(4) == 0) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
                push_char(8'($urandom_range(255)), 1'b0, 6'($urandom_range(63)));
            end
        end
    endtask

    initial begin
        int unsigned base_count;
        sb = new(MAX_CHARS);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed strings ----------------
        // characters before any string opens are ignored
        put_text("99");
        // every blank, then the most negative value
        open_text(RADIX_DEC, " ");
        put(CH_TAB); put(CH_LF); put(CH_CR); put(CH_VT); put(CH_FF);
        put_text("-9223372036854775808");
        put(CH_NUL);
        // auto radix picks hex after a sign
        open_text(RADIX_AUTO, "+0x7fffffffffffffff");
        put(CH_NUL);
        // prefix with no hex digit after it still counts as consumed
        open_text(RADIX_HEX, "0Xg");
        // lone zero selects octal; 8 stops the parse
        open_text(RADIX_AUTO, "08");
        open_text(RADIX_AUTO, "0777");
        put(CH_NUL);
        // radix 10 stops on the x after the zero
        open_text(RADIX_DEC, "0x1");
        // radix 1 stops on the 5, radix 63 takes every digit
        open_text(6'd1, "5");
        open_text(6'd63, "zZ9");
        put(CH_NUL);
        open_text(6'd36, "-zz+");
        // second sign, blank after sign
        open_text(RADIX_DEC, "+-5");
        open_text(RADIX_DEC, "- 5");
        // wrap of the accumulator
        open_text(6'd2, "");
        for (int i = 0; i < 70; i++) put(CH_ZERO + 8'd1);
        put(CH_NUL);
        // dropped characters after a result
        put_text("abc");
        // a new string abandons the one in flight
        open_text(RADIX_DEC, "123");
        open_text(RADIX_DEC, "45");
        put(CH_NUL);
        // top character code, and a terminator opening a string
        open_text(RADIX_DEC, "");
        put(8'hFF);
        open_text(RADIX_DEC, "");
        put(CH_NUL);
        drain();

        // ---------------- random strings ----------------
        base_count = chars_sent;
        while (chars_sent - base_count < RANDOM_ITEMS / 3) random_text();
        drain();
        send_idle_pct = 58;
        out_stall_pct = 29;
        while (chars_sent - base_count < 2 * RANDOM_ITEMS / 3) random_text();
        drain();
        send_idle_pct = 0;
        out_stall_pct = 0;
        while (chars_sent - base_count < RANDOM_ITEMS) random_text();
        // make sure the last string produces a result
        lead       = 1'b1;
        lead_radix = RADIX_DEC;
        put(CH_NUL);

        // wait out the pipeline, then settle
        drain();
        repeat (10) @(posedge clk);
        sb.close_out();

        $display("Run covered %0d strings and %0d characters, %0d results checked,",
                 strings_opened, chars_sent, sb.results_seen);
        $display("idling sender/receiver 29/58 percent, then 58/29, then none.");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

>>> text_to_integer_parser.f
hdl/tip_pkg.sv
hdl/tip_core.sv
hdl/text_to_integer_parser.sv
tb/text_to_integer_parser_tb.sv
